### hw/rtl/sor_pkg.sv
// shared constants, command codes and the shape descriptor type for the outline rasterizer
`timescale 1ns / 1ps

package sor_pkg;

    // screen and size limits
    localparam int SCREEN_WIDTH  = 20;
    localparam int SCREEN_HEIGHT = 10;
    localparam int MAX_SIZE      = 16;
    localparam int MAX_RADIUS    = 8;
    localparam int RESULT_CAP    = 64;

    // field and working widths
    localparam int X_W    = 5;
    localparam int Y_W    = 4;
    localparam int SIZE_W = 5;
    localparam int H_W    = 4;
    localparam int R2_W   = 7;
    localparam int CNT_W  = 7;
    localparam int OFF_W  = 8;

    typedef enum logic [1:0] {
        CMD_TRI    = 2'd0,
        CMD_SQUARE = 2'd1,
        CMD_RECT   = 2'd2,
        CMD_CIRCLE = 2'd3
    } t_cmd;

    // shape held for the whole scan
    typedef struct packed {
        t_cmd              shape;
        logic [SIZE_W-1:0] a;
        logic [SIZE_W-1:0] b;
        logic [H_W-1:0]    h;
        logic [R2_W-1:0]   r2;
    } t_shape_cfg;

endpackage

### hw/rtl/shape_outline_rasterizer.sv
// top level: command capture, origin wrap, box scan sequencer and result register
// origin wrap first, then one box cell per cycle while the output does not stall, over a box
// of at most 17*17 = 289 cells, ending early at the result cap; then the final cell is released
// a new command is taken only once the sequencer is back in idle, set by the single cell test
// that the scan sequencer steps through the box; output stalls pause the scan
// reset: synchronous, active low; clears the sequencer, pending cell, count and out valid
`timescale 1ns / 1ps

module shape_outline_rasterizer import sor_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [X_W-1:0]    i_origin_x,
    input  logic [Y_W-1:0]    i_origin_y,
    input  logic [SIZE_W-1:0] i_size_a,
    input  logic [SIZE_W-1:0] i_size_b,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [X_W-1:0]    o_point_x,
    output logic [Y_W-1:0]    o_point_y,
    output logic              o_last
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_WRAP  = 4'b0010,
        S_SCAN  = 4'b0100,
        S_FLUSH = 4'b1000
    } t_state;

    t_state                  r_state, n_state;
    t_shape_cfg              r_cfg, n_cfg;
    logic [SIZE_W-1:0]       r_rows, n_rows;
    logic [SIZE_W-1:0]       r_cols, n_cols;
    logic [SIZE_W-1:0]       r_i, n_i;
    logic [SIZE_W-1:0]       r_j, n_j;
    logic signed [OFF_W-1:0] r_vx, n_vx;
    logic signed [OFF_W-1:0] r_vy, n_vy;
    logic [X_W-1:0]          r_cx, n_cx;
    logic [X_W-1:0]          r_cx0, n_cx0;
    logic [Y_W-1:0]          r_cy, n_cy;
    logic [CNT_W-1:0]        r_count, n_count;
    logic                    r_pend_valid, n_pend_valid;
    logic [X_W-1:0]          r_pend_x, n_pend_x;
    logic [Y_W-1:0]          r_pend_y, n_pend_y;
    logic                    r_out_valid, n_out_valid;
    logic [X_W-1:0]          r_out_x, n_out_x;
    logic [Y_W-1:0]          r_out_y, n_out_y;
    logic                    r_out_last, n_out_last;

    logic                    hit;
    logic                    out_free;
    logic                    box_end;
    logic                    x_ok;
    logic                    y_ok;
    logic [SIZE_W-1:0]       a_sat;
    logic [SIZE_W-1:0]       b_sat;
    logic [H_W-1:0]          h_new;
    logic [SIZE_W-1:0]       span;
    logic signed [OFF_W-1:0] off_new;
    t_cmd                    cmd;

    assign cmd = t_cmd'(i_cmd);

    // cell test on the current box position
    sor_cell_test u_cell (
        .i_cfg (r_cfg),
        .i_row (r_i),
        .i_col (r_j),
        .o_hit (hit)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_out_x;
    assign o_point_y   = r_out_y;
    assign o_last      = r_out_last;

    assign out_free = !r_out_valid || i_out_ready;
    assign box_end  = (r_i == r_rows - 1'b1) && (r_j == r_cols - 1'b1);
    assign x_ok     = (r_vx >= 0) && (r_vx < OFF_W'(SCREEN_WIDTH));
    assign y_ok     = (r_vy >= 0) && (r_vy < OFF_W'(SCREEN_HEIGHT));

    // size saturation and box geometry of a new command
    always_comb begin
        if (cmd == CMD_CIRCLE) begin
            a_sat = (i_size_a > SIZE_W'(MAX_RADIUS)) ? SIZE_W'(MAX_RADIUS) : i_size_a;
        end else begin
            a_sat = (i_size_a > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : i_size_a;
        end
        b_sat   = (i_size_b > SIZE_W'(MAX_SIZE)) ? SIZE_W'(MAX_SIZE) : i_size_b;
        h_new   = H_W'(a_sat >> 1) + 1'b1;
        span    = SIZE_W'({a_sat[SIZE_W-2:0], 1'b1});
        off_new = (cmd == CMD_CIRCLE) ? $signed({3'b000, a_sat}) : '0;
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_cfg        = r_cfg;
        n_rows       = r_rows;
        n_cols       = r_cols;
        n_i          = r_i;
        n_j          = r_j;
        n_vx         = r_vx;
        n_vy         = r_vy;
        n_cx         = r_cx;
        n_cx0        = r_cx0;
        n_cy         = r_cy;
        n_count      = r_count;
        n_pend_valid = r_pend_valid;
        n_pend_x     = r_pend_x;
        n_pend_y     = r_pend_y;
        n_out_valid  = r_out_valid;
        n_out_x      = r_out_x;
        n_out_y      = r_out_y;
        n_out_last   = r_out_last;

        // output register drains on a taken transaction
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_cfg.shape = cmd;
                    n_cfg.a     = a_sat;
                    n_cfg.b     = b_sat;
                    n_cfg.h     = h_new;
                    n_cfg.r2    = R2_W'(a_sat) * R2_W'(a_sat);
                    case (cmd)
                        CMD_TRI:    n_rows = SIZE_W'(h_new);
                        CMD_SQUARE: n_rows = a_sat;
                        CMD_RECT:   n_rows = b_sat;
                        default:    n_rows = span;
                    endcase
                    n_cols  = (cmd == CMD_CIRCLE) ? span : a_sat;
                    n_vx    = $signed({3'b000, i_origin_x}) - off_new;
                    n_vy    = $signed({4'b0000, i_origin_y}) - off_new;
                    n_i     = '0;
                    n_j     = '0;
                    n_count = '0;
                    n_state = S_WRAP;
                end
            end
            S_WRAP: begin
                // one add or subtract of the screen size per cycle on each axis
                if (r_vx < 0) begin
                    n_vx = r_vx + OFF_W'(SCREEN_WIDTH);
                end else if (!x_ok) begin
                    n_vx = r_vx - OFF_W'(SCREEN_WIDTH);
                end
                if (r_vy < 0) begin
                    n_vy = r_vy + OFF_W'(SCREEN_HEIGHT);
                end else if (!y_ok) begin
                    n_vy = r_vy - OFF_W'(SCREEN_HEIGHT);
                end
                if (x_ok && y_ok) begin
                    n_cx  = r_vx[X_W-1:0];
                    n_cx0 = r_vx[X_W-1:0];
                    n_cy  = r_vy[Y_W-1:0];
                    if (r_rows == '0 || r_cols == '0) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // a hit with a cell already pending needs the output register
                if (!(hit && r_pend_valid && !out_free)) begin
                    if (hit) begin
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_x     = r_pend_x;
                            n_out_y     = r_pend_y;
                            n_out_last  = 1'b0;
                        end
                        n_pend_valid = 1'b1;
                        n_pend_x     = r_cx;
                        n_pend_y     = r_cy;
                        n_count      = r_count + 1'b1;
                    end
                    // step to the next cell, row-major
                    if (box_end || (hit && r_count == CNT_W'(RESULT_CAP - 1))) begin
                        n_state = S_FLUSH;
                    end else if (r_j == r_cols - 1'b1) begin
                        n_j  = '0;
                        n_i  = r_i + 1'b1;
                        n_cx = r_cx0;
                        n_cy = (r_cy == Y_W'(SCREEN_HEIGHT - 1)) ? '0 : r_cy + 1'b1;
                    end else begin
                        n_j  = r_j + 1'b1;
                        n_cx = (r_cx == X_W'(SCREEN_WIDTH - 1)) ? '0 : r_cx + 1'b1;
                    end
                end
            end
            S_FLUSH: begin
                // release the final cell with last set
                if (!r_pend_valid) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_x      = r_pend_x;
                    n_out_y      = r_pend_y;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        r_cfg      <= n_cfg;
        r_rows     <= n_rows;
        r_cols     <= n_cols;
        r_i        <= n_i;
        r_j        <= n_j;
        r_vx       <= n_vx;
        r_vy       <= n_vy;
        r_cx       <= n_cx;
        r_cx0      <= n_cx0;
        r_cy       <= n_cy;
        r_pend_x   <= n_pend_x;
        r_pend_y   <= n_pend_y;
        r_out_x    <= n_out_x;
        r_out_y    <= n_out_y;
        r_out_last <= n_out_last;
    end

`ifndef NO_ASSERTIONS
    // result count never passes the cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(RESULT_CAP))
        else $error("result count above cap");

    // nothing is left pending once the sequencer is back to idle
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_pend_valid)
        else $error("pending cell left in idle");

    // an accepted command starts the origin wrap
    a_accept_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_WRAP))
        else $error("accepted command did not start");

    // scan position stays inside the box
    a_scan_in_box: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_i < r_rows) && (r_j < r_cols))
        else $error("scan position outside box");

    // wrapped screen coordinates stay on the screen during the scan
    a_scan_on_screen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_cx < X_W'(SCREEN_WIDTH)) && (r_cy < Y_W'(SCREEN_HEIGHT)))
        else $error("screen coordinate out of range");
`endif

endmodule

### hw/rtl/sor_cell_test.sv
// outline membership test for one cell of the bounding box
`timescale 1ns / 1ps

module sor_cell_test import sor_pkg::*; (
    input  t_shape_cfg        i_cfg,
    input  logic [SIZE_W-1:0] i_row,
    input  logic [SIZE_W-1:0] i_col,
    output logic              o_hit
);

    logic signed [OFF_W-1:0] off;
    logic signed [OFF_W-1:0] di;
    logic signed [OFF_W-1:0] dj;
    logic signed [OFF_W-1:0] a_s;
    logic signed [OFF_W-1:0] b_s;
    logic signed [OFF_W-1:0] h_s;
    logic signed [15:0]      sq_i;
    logic signed [15:0]      sq_j;
    logic signed [15:0]      dsq;
    logic signed [15:0]      r2_s;

    // box index to signed offset from the origin
    assign off  = (i_cfg.shape == CMD_CIRCLE) ? $signed({3'b000, i_cfg.a}) : '0;
    assign di   = $signed({3'b000, i_row}) - off;
    assign dj   = $signed({3'b000, i_col}) - off;
    assign a_s  = $signed({3'b000, i_cfg.a});
    assign b_s  = $signed({3'b000, i_cfg.b});
    assign h_s  = $signed({4'b0000, i_cfg.h});

    // squared distance for the circle
    assign sq_i = 16'(di * di);
    assign sq_j = 16'(dj * dj);
    assign dsq  = sq_i + sq_j;
    assign r2_s = $signed({9'd0, i_cfg.r2});

    // per-shape outline rule
    always_comb begin
        case (i_cfg.shape)
            CMD_TRI: begin
                o_hit = (dj == h_s - di - 8'sd1) || (dj == h_s + di) || (di == h_s - 8'sd1);
            end
            CMD_SQUARE: begin
                o_hit = (di == 8'sd0) || (di == a_s - 8'sd1)
                     || (dj == 8'sd0) || (dj == a_s - 8'sd1);
            end
            CMD_RECT: begin
                o_hit = (di == 8'sd0) || (di == b_s - 8'sd1)
                     || (dj == 8'sd0) || (dj == a_s - 8'sd1);
            end
            default: begin
                o_hit = (dsq <= r2_s + 16'sd1) && (dsq >= r2_s - 16'sd1);
            end
        endcase
    end

endmodule

### tb/sv/shape_outline_rasterizer_tb.sv
// testbench for the outline rasterizer: shape commands in, outline points checked one by one
`timescale 1ns / 1ps

module shape_outline_rasterizer_tb;
    import sor_pkg::*;

    localparam int CLK_PERIOD    = 20;
    localparam int RESET_CYCLES  = 3;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 400;
    localparam int IDLE_PCT      = 25;
    localparam int MAX_REPORTS   = 50;
    localparam int HOLD_CYCLES   = 1000;

    // one expected outline point
    typedef struct packed {
        logic [X_W-1:0] x;
        logic [Y_W-1:0] y;
        logic           last;
    } t_point;

    logic              i_clk      = 1'b0;
    logic              i_rst_n    = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic [1:0]        i_cmd      = '0;
    logic [X_W-1:0]    i_origin_x = '0;
    logic [Y_W-1:0]    i_origin_y = '0;
    logic [SIZE_W-1:0] i_size_a   = '0;
    logic [SIZE_W-1:0] i_size_b   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [X_W-1:0]    o_point_x;
    logic [Y_W-1:0]    o_point_y;
    logic              o_last;

    t_point outline_points[$];
    t_point want;
    int     mismatch_count = 0;
    int     cycle_count    = 0;
    bit     send_idle_on   = 1'b1;
    bit     take_idle_on   = 1'b1;
    int     hold_request   = 0;
    int     hold_left      = 0;

    shape_outline_rasterizer uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_origin_x  (i_origin_x),
        .i_origin_y  (i_origin_y),
        .i_size_a    (i_size_a),
        .i_size_b    (i_size_b),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_point_x   (o_point_x),
        .o_point_y   (o_point_y),
        .o_last      (o_last)
    );

    // clock
    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // run limit
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("end of test: mismatches");
        $finish;
    end

    task automatic report_error(string what);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("ERROR at %0t ns: %s", $realtime, what);
        end
    endtask

    // coordinate reduced onto the screen, either direction
    function automatic int wrap_screen(int v, int span);
        int r;
        r = v % span;
        if (r < 0) begin
            r += span;
        end
        return r;
    endfunction

    // outline test for one box cell, offsets relative to the origin
    function automatic bit cell_on_outline(t_cmd shape, int di, int dj, int a, int b);
        int h;
        int d;
        h = a / 2 + 1;
        d = di * di + dj * dj;
        case (shape)
            CMD_TRI:    return dj == h - di - 1 || dj == h + di || di == h - 1;
            CMD_SQUARE: return di == 0 || di == a - 1 || dj == 0 || dj == a - 1;
            CMD_RECT:   return di == 0 || di == b - 1 || dj == 0 || dj == a - 1;
            default:    return d <= a * a + 1 && d >= a * a - 1;
        endcase
    endfunction

    // row-major scan of the bounding box, appends the outline points of one command
    function automatic void trace_outline(t_cmd shape, int ox, int oy, int a, int b);
        t_point cells[$];
        t_point pt;
        int     rows;
        int     cols;
        int     first;
        int     di;
        int     dj;
        if (shape == CMD_CIRCLE) begin
            if (a > MAX_RADIUS) a = MAX_RADIUS;
        end else if (a > MAX_SIZE) begin
            a = MAX_SIZE;
        end
        if (b > MAX_SIZE) b = MAX_SIZE;
        first = 0;
        case (shape)
            CMD_TRI: begin
                rows = a / 2 + 1;
                cols = a;
            end
            CMD_SQUARE: begin
                rows = a;
                cols = a;
            end
            CMD_RECT: begin
                rows = b;
                cols = a;
            end
            default: begin
                rows  = 2 * a + 1;
                cols  = 2 * a + 1;
                first = -a;
            end
        endcase
        if (cols == 0) rows = 0;
        for (int i = 0; i < rows; i++) begin
            for (int j = 0; j < cols; j++) begin
                di = first + i;
                dj = first + j;
                if (cell_on_outline(shape, di, dj, a, b) && cells.size() < RESULT_CAP) begin
                    pt.x    = X_W'(wrap_screen(ox + dj, SCREEN_WIDTH));
                    pt.y    = Y_W'(wrap_screen(oy + di, SCREEN_HEIGHT));
                    pt.last = 1'b0;
                    cells.push_back(pt);
                end
            end
        end
        if (cells.size() > 0) cells[cells.size() - 1].last = 1'b1;
        foreach (cells[k]) outline_points.push_back(cells[k]);
    endfunction

    // one command transaction; valid stays up if the next call follows without a gap
    task automatic send_shape(t_cmd shape, int ox, int oy, int a, int b);
        while (send_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_cmd      <= shape;
        i_origin_x <= X_W'(ox);
        i_origin_y <= Y_W'(oy);
        i_size_a   <= SIZE_W'(a);
        i_size_b   <= SIZE_W'(b);
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        trace_outline(shape, ox % 32, oy % 16, a % 32, b % 32);
    endtask

    // drop valid and wait until every expected point has come back
    task automatic wait_drained(int settle);
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outline_points.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // sizes are mostly small, now and then up to the saturating range
    function automatic int pick_size();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 80) return $urandom_range(0, 9);
        if (roll < 93) return $urandom_range(10, 16);
        return $urandom_range(17, 31);
    endfunction

    // output side: random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (take_idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // compare each accepted point transaction against the oldest expected point
    always @(posedge i_clk) begin
        if (i_rst_n && i_out_ready && o_out_valid !== 1'b0) begin
            if (outline_points.size() == 0) begin
                report_error($sformatf("point (%0d,%0d) last=%0b with nothing expected",
                                       o_point_x, o_point_y, o_last));
            end else begin
                want = outline_points.pop_front();
                if (o_point_x !== want.x)
                    report_error($sformatf("point_x %0d, expected %0d", o_point_x, want.x));
                if (o_point_y !== want.y)
                    report_error($sformatf("point_y %0d, expected %0d", o_point_y, want.y));
                if (o_last !== want.last)
                    report_error($sformatf("last %0b, expected %0b at (%0d,%0d)",
                                           o_last, want.last, want.x, want.y));
            end
        end
    end

    // extremes of every field, every shape, empty shapes, wrap and saturation
    task automatic test_directed_shapes();
        send_shape(CMD_TRI,     0,  0,  0, 31);
        send_shape(CMD_TRI,     0,  0,  1,  0);
        send_shape(CMD_TRI,    19,  9,  2,  0);
        send_shape(CMD_TRI,     5,  2,  7,  3);
        send_shape(CMD_TRI,    10,  5, 16,  0);
        send_shape(CMD_TRI,    31, 15, 31,  0);
        send_shape(CMD_SQUARE,  4,  4,  0, 31);
        send_shape(CMD_SQUARE, 31, 15,  1,  0);
        send_shape(CMD_SQUARE,  0,  9,  2,  0);
        send_shape(CMD_SQUARE,  3,  0, 16,  0);
        send_shape(CMD_SQUARE, 19,  0, 31, 17);
        send_shape(CMD_RECT,    2,  2,  0,  5);
        send_shape(CMD_RECT,    2,  2,  5,  0);
        send_shape(CMD_RECT,    0,  0,  1,  1);
        send_shape(CMD_RECT,   18,  8, 16,  3);
        send_shape(CMD_RECT,    0,  0,  3, 16);
        send_shape(CMD_RECT,   31, 15, 31, 31);
        send_shape(CMD_RECT,   10,  5, 20, 10);
        send_shape(CMD_CIRCLE,  0,  0,  0,  0);
        send_shape(CMD_CIRCLE,  0,  0,  1,  0);
        send_shape(CMD_CIRCLE, 19,  9,  2,  0);
        send_shape(CMD_CIRCLE, 10,  5,  5, 31);
        send_shape(CMD_CIRCLE, 31, 15,  8,  0);
        send_shape(CMD_CIRCLE,  0,  0, 31, 31);
        send_shape(CMD_CIRCLE,  2,  3, 16,  0);
        wait_drained(0);
    endtask

    // random commands with idling on both sides
    task automatic test_random_shapes(int count);
        for (int n = 0; n < count; n++) begin
            send_shape(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 31),
                       $urandom_range(0, 15), pick_size(), pick_size());
        end
        wait_drained(0);
    endtask

    // back to back commands, no idling on either side
    task automatic test_no_idle_stretch(int count);
        send_idle_on = 1'b0;
        take_idle_on = 1'b0;
        test_random_shapes(count);
        send_idle_on = 1'b1;
        take_idle_on = 1'b1;
    endtask

    // long output hold-off while commands keep coming, so the input stalls
    task automatic test_output_backpressure();
        hold_request = HOLD_CYCLES;
        for (int n = 0; n < 10; n++) begin
            send_shape(t_cmd'(n % 4), $urandom_range(0, 31), $urandom_range(0, 15),
                       $urandom_range(4, 9), $urandom_range(4, 9));
        end
        wait_drained(0);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_shapes();
        test_random_shapes(200);
        test_no_idle_stretch(45);
        test_output_backpressure();
        test_random_shapes(150);
        wait_drained(SETTLE_CYCLES);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/sor_pkg.sv
hw/rtl/sor_cell_test.sv
hw/rtl/shape_outline_rasterizer.sv
tb/sv/shape_outline_rasterizer_tb.sv
